[rtl/rcbr_pkg.sv]
package rcbr_pkg;

    // table geometry
    localparam int NODE_COUNT   = 16;
    localparam int NODE_FIELD_W = 4;
    localparam int NODE_W       = $clog2(NODE_COUNT);
    localparam int EDGE_DEPTH   = NODE_COUNT * NODE_COUNT;
    localparam int EDGE_AW      = $clog2(EDGE_DEPTH);

    // field widths
    localparam int WT_W    = 16;
    localparam int DEM_W   = 8;
    localparam int LOAD_W  = 16;
    localparam int COST_W  = 21;
    localparam int IDX_W   = 32;
    localparam int PROD_W  = LOAD_W + COST_W;

    localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};
    localparam logic [IDX_W-1:0]  IDX_MAX   = {IDX_W{1'b1}};
    localparam logic [LOAD_W-1:0] CAP_RESET = LOAD_W'(15);
    localparam logic [COST_W-1:0] COST_ONE  = COST_W'(1);

    // hop queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // input word kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_EDGE   = 2'd0;
    localparam t_kind KIND_DEMAND = 2'd1;
    localparam t_kind KIND_NODE   = 2'd2;

    // one looked-up hop, front to back
    typedef struct packed {
        logic              present;
        logic [WT_W-1:0]   weight;
        logic [DEM_W-1:0]  demand;
        logic              last;
    } t_hop;

    // one route result
    typedef struct packed {
        logic              route_valid;
        logic [COST_W-1:0] route_cost;
        logic [LOAD_W-1:0] route_value;
        logic              new_best;
        logic              have_best;
        logic [COST_W-1:0] rec_cost;
        logic [LOAD_W-1:0] best_value;
        logic [IDX_W-1:0]  best_route_index;
    } t_result;

endpackage

[rtl/rcbr_front.sv]
module rcbr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    output logic                                o_rdy,
    input  rcbr_pkg::t_kind                     i_kind,
    input  logic [rcbr_pkg::NODE_FIELD_W-1:0]   i_from,
    input  logic [rcbr_pkg::NODE_FIELD_W-1:0]   i_to,
    input  logic [rcbr_pkg::WT_W-1:0]           i_weight,
    input  logic                                i_exists,
    input  logic [rcbr_pkg::DEM_W-1:0]          i_demand,
    input  logic                                i_last,
    output logic                                o_push,
    input  logic                                i_push_rdy,
    output rcbr_pkg::t_hop                      o_hop
);

    logic [rcbr_pkg::WT_W-1:0]         r_wt_mem [rcbr_pkg::EDGE_DEPTH];
    logic [rcbr_pkg::EDGE_DEPTH-1:0]   r_present;
    logic [rcbr_pkg::DEM_W-1:0]        r_dem [rcbr_pkg::NODE_COUNT];
    logic [rcbr_pkg::NODE_FIELD_W-1:0] r_cur;

    logic                              r_st_vld, n_st_vld;
    logic                              r_st_last;
    logic                              r_st_rng;
    logic [rcbr_pkg::WT_W-1:0]         r_wt_q;
    logic                              r_pr_q;
    logic [rcbr_pkg::DEM_W-1:0]        r_dm_q;

    logic                              w_acc, w_node, w_edge_wr, w_dem_wr, w_push;
    logic                              w_from_ok, w_to_ok, w_cur_ok;
    logic [rcbr_pkg::EDGE_AW-1:0]      w_wr_addr, w_rd_addr;
    logic [rcbr_pkg::NODE_W-1:0]       w_from_idx, w_to_idx;

    assign o_rdy     = !r_st_vld || i_push_rdy;
    assign w_acc     = i_vld && o_rdy;
    assign w_push    = r_st_vld && i_push_rdy;

    assign w_from_ok = int'(i_from) < rcbr_pkg::NODE_COUNT;
    assign w_to_ok   = int'(i_to) < rcbr_pkg::NODE_COUNT;
    assign w_cur_ok  = int'(r_cur) < rcbr_pkg::NODE_COUNT;

    assign w_from_idx = rcbr_pkg::NODE_W'(i_from);
    assign w_to_idx   = rcbr_pkg::NODE_W'(i_to);
    assign w_wr_addr  = rcbr_pkg::EDGE_AW'(int'(i_from) * rcbr_pkg::NODE_COUNT + int'(i_to));
    assign w_rd_addr  = rcbr_pkg::EDGE_AW'(int'(r_cur) * rcbr_pkg::NODE_COUNT + int'(i_to));

    assign w_edge_wr = w_acc && (i_kind == rcbr_pkg::KIND_EDGE) && w_from_ok && w_to_ok;
    assign w_dem_wr  = w_acc && (i_kind == rcbr_pkg::KIND_DEMAND) && w_from_ok;
    assign w_node    = w_acc && (i_kind == rcbr_pkg::KIND_NODE);

    // edge weights: no reset, only read behind a set presence bit
    always_ff @(posedge i_clk) begin
        if (w_edge_wr) begin
            r_wt_mem[w_wr_addr] <= i_weight;
        end
        if (w_node) begin
            r_wt_q <= r_wt_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            for (int k = 0; k < rcbr_pkg::NODE_COUNT; k++) begin
                r_dem[k] <= '0;
            end
        end else begin
            if (w_edge_wr) begin
                r_present[w_wr_addr] <= i_exists;
            end
            if (w_dem_wr) begin
                r_dem[w_from_idx] <= i_demand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_node) begin
            r_pr_q    <= r_present[w_rd_addr];
            r_dm_q    <= r_dem[w_to_idx];
            r_st_last <= i_last;
            r_st_rng  <= w_to_ok && w_cur_ok;
        end
    end

    always_comb begin
        n_st_vld = r_st_vld;
        if (w_node) begin
            n_st_vld = 1'b1;
        end else if (w_push) begin
            n_st_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= 1'b0;
            r_cur    <= '0;
        end else begin
            r_st_vld <= n_st_vld;
            if (w_node) begin
                r_cur <= i_last ? '0 : i_to;
            end
        end
    end

    assign o_push = r_st_vld;
    assign o_hop  = '{present: r_pr_q && r_st_rng,
                      weight:  r_wt_q,
                      demand:  r_dm_q,
                      last:    r_st_last};

endmodule

[rtl/rcbr_fifo.sv]
module rcbr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_rdy,
    input  rcbr_pkg::t_hop  i_data,
    output logic            o_vld,
    input  logic            i_pop,
    output rcbr_pkg::t_hop  o_data
);

    rcbr_pkg::t_hop                r_mem [rcbr_pkg::FIFO_DEPTH];
    logic [rcbr_pkg::FIFO_AW-1:0]  r_wp, r_rp;
    logic [rcbr_pkg::FIFO_AW:0]    r_cnt;
    logic                          w_wr, w_rd;

    assign o_push_rdy = r_cnt != (rcbr_pkg::FIFO_AW+1)'(rcbr_pkg::FIFO_DEPTH);
    assign o_vld      = r_cnt != '0;
    assign w_wr       = i_push && o_push_rdy;
    assign w_rd       = i_pop && o_vld;
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/rcbr_back.sv]
module rcbr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rcbr_pkg::LOAD_W-1:0]   i_cap,
    input  logic                          i_vld,
    output logic                          o_pop,
    input  rcbr_pkg::t_hop                i_hop,
    output logic                          o_vld,
    input  logic                          i_rdy,
    output rcbr_pkg::t_result             o_res
);

    // running route
    logic                          r_ok;
    logic [rcbr_pkg::LOAD_W-1:0]   r_load;
    logic [rcbr_pkg::COST_W-1:0]   r_cost;
    // finished route
    logic                          r_e_vld;
    logic                          r_e_ok;
    logic [rcbr_pkg::LOAD_W-1:0]   r_e_load;
    logic [rcbr_pkg::COST_W-1:0]   r_e_cost;
    // cross products
    logic                          r_c_vld;
    logic                          r_c_ok;
    logic [rcbr_pkg::LOAD_W-1:0]   r_c_load;
    logic [rcbr_pkg::COST_W-1:0]   r_c_cost;
    logic [rcbr_pkg::PROD_W-1:0]   r_c_lhs, r_c_rhs;
    // best record
    logic                          r_have;
    logic [rcbr_pkg::LOAD_W-1:0]   r_bv;
    logic [rcbr_pkg::COST_W-1:0]   r_bc;
    logic [rcbr_pkg::IDX_W-1:0]    r_bi;
    logic [rcbr_pkg::IDX_W-1:0]    r_cnt;
    // output
    logic                          r_o_vld;
    rcbr_pkg::t_result             r_o;

    logic                          w_pop, w_good, w_fit, w_win;
    logic                          w_o_take, w_c_go, w_e_go, w_e_free;
    logic [rcbr_pkg::LOAD_W:0]     w_sum_load;
    logic [rcbr_pkg::COST_W:0]     w_sum_cost;
    logic                          n_ok;
    logic [rcbr_pkg::LOAD_W-1:0]   n_load;
    logic [rcbr_pkg::COST_W-1:0]   n_cost;

    assign w_o_take = !r_o_vld || i_rdy;
    assign w_c_go   = r_c_vld && w_o_take;
    // products read the best record, so wait until the compare stage is empty
    assign w_e_go   = r_e_vld && !r_c_vld;
    assign w_e_free = !r_e_vld || w_e_go;
    assign o_pop    = i_vld && (!i_hop.last || w_e_free);
    assign w_pop    = o_pop;

    assign w_sum_load = {1'b0, r_load} + (rcbr_pkg::LOAD_W+1)'(i_hop.demand);
    assign w_fit      = w_sum_load <= {1'b0, i_cap};
    assign w_sum_cost = {1'b0, r_cost} + (rcbr_pkg::COST_W+1)'(i_hop.weight);
    assign w_good     = r_ok && i_hop.present && w_fit;

    always_comb begin
        n_ok   = r_ok && w_good;
        n_load = r_load;
        n_cost = r_cost;
        if (w_good) begin
            n_load = w_sum_load[rcbr_pkg::LOAD_W-1:0];
            n_cost = w_sum_cost[rcbr_pkg::COST_W] ? rcbr_pkg::COST_MAX
                                                   : w_sum_cost[rcbr_pkg::COST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok   <= 1'b1;
            r_load <= '0;
            r_cost <= '0;
        end else if (w_pop) begin
            if (i_hop.last) begin
                r_ok   <= 1'b1;
                r_load <= '0;
                r_cost <= '0;
            end else begin
                r_ok   <= n_ok;
                r_load <= n_load;
                r_cost <= n_cost;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_hop.last) begin
            r_e_ok   <= n_ok;
            r_e_load <= n_load;
            r_e_cost <= n_cost;
        end
        if (w_e_go) begin
            r_c_ok   <= r_e_ok;
            r_c_load <= r_e_load;
            r_c_cost <= r_e_cost;
            r_c_lhs  <= rcbr_pkg::PROD_W'(r_e_load) * rcbr_pkg::PROD_W'(r_bc);
            r_c_rhs  <= rcbr_pkg::PROD_W'(r_bv) * rcbr_pkg::PROD_W'(r_e_cost);
        end
    end

    assign w_win = r_c_ok && (r_c_lhs > r_c_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_have  <= 1'b0;
            r_bv    <= '0;
            r_bc    <= rcbr_pkg::COST_ONE;
            r_bi    <= '0;
            r_cnt   <= '0;
        end else begin
            if (w_pop && i_hop.last) begin
                r_e_vld <= 1'b1;
            end else if (w_e_go) begin
                r_e_vld <= 1'b0;
            end
            if (w_e_go) begin
                r_c_vld <= 1'b1;
            end else if (w_c_go) begin
                r_c_vld <= 1'b0;
            end
            if (w_c_go) begin
                r_o_vld <= 1'b1;
            end else if (i_rdy) begin
                r_o_vld <= 1'b0;
            end
            if (w_c_go) begin
                if (w_win) begin
                    r_have <= 1'b1;
                    r_bv   <= r_c_load;
                    r_bc   <= r_c_cost;
                    r_bi   <= r_cnt;
                end
                if (r_cnt != rcbr_pkg::IDX_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_go) begin
            r_o.route_valid      <= r_c_ok;
            r_o.route_cost       <= r_c_cost;
            r_o.route_value      <= r_c_load;
            r_o.new_best         <= w_win;
            r_o.have_best        <= r_have || w_win;
            r_o.rec_cost         <= w_win ? r_c_cost : r_bc;
            r_o.best_value       <= w_win ? r_c_load : r_bv;
            r_o.best_route_index <= w_win ? r_cnt : r_bi;
        end
    end

    assign o_vld = r_o_vld;
    assign o_res = r_o;

endmodule

[rtl/route_check_and_best_ratio.sv]
// Channel   Dir  Handshake                 Payload
// -------   ---  ------------------------  --------------------------------------------
// s (in)    in   i_s_tvalid / o_s_tready   tdata: from, to, weight, exists, demand
//                                          tuser: kind, tlast: last node of route
// m (out)   out  o_m_tvalid / i_m_tready   tdata: one route result per route end
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_data: load capacity
//
// One word per cycle is taken in steady state, while the hop queue has room. A
// route result passes the lookup, queue, accumulate, multiply and compare stages
// after the edge that takes its last node. A finished route waits in the back end
// until the one before it has left the multiply stage, as the best record is read
// by the multiply stage and written by the compare stage after it.
// Reset (synchronous, active low) clears presence bits, demands, route state and
// the best record at once; no clearing pass. Input and output stall independently:
// the hop queue and the output register part the two sides.
module route_check_and_best_ratio (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input words
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // [3:0] node_from, [7:4] node_to, [23:8] weight, [24] edge_exists,
    // [32:25] demand_amount, [39:33] zero
    input  logic [39:0]                            i_s_tdata,
    input  logic                                   i_s_tlast,
    // [1:0] kind
    input  logic [1:0]                             i_s_tuser,
    // results
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // [0] route_valid, [21:1] route_cost, [37:22] route_value, [38] new_best,
    // [39] have_best, [60:40] rec_cost, [76:61] best_value,
    // [108:77] best_route_index, [111:109] zero
    output logic [111:0]                           o_m_tdata,
    // capacity register
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rcbr_pkg::LOAD_W-1:0]            i_cfg_data
);

    logic [rcbr_pkg::LOAD_W-1:0] r_cap;

    logic               w_push, w_push_rdy;
    rcbr_pkg::t_hop     w_push_hop;
    logic               w_q_vld, w_q_pop;
    rcbr_pkg::t_hop     w_q_hop;
    rcbr_pkg::t_result  w_res;

    // the user must write capacity only while idle; the block does not enforce it; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= rcbr_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // front: table writes and lookups, in arrival order
    rcbr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_s_tvalid),
        .o_rdy      (o_s_tready),
        .i_kind     (i_s_tuser),
        .i_from     (i_s_tdata[3:0]),
        .i_to       (i_s_tdata[7:4]),
        .i_weight   (i_s_tdata[23:8]),
        .i_exists   (i_s_tdata[24]),
        .i_demand   (i_s_tdata[32:25]),
        .i_last     (i_s_tlast),
        .o_push     (w_push),
        .i_push_rdy (w_push_rdy),
        .o_hop      (w_push_hop)
    );

    // hop queue between lookup and accumulation
    rcbr_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_push_rdy (w_push_rdy),
        .i_data     (w_push_hop),
        .o_vld      (w_q_vld),
        .i_pop      (w_q_pop),
        .o_data     (w_q_hop)
    );

    // back: hop checks, running sums, best-ratio record
    rcbr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_cap),
        .i_vld   (w_q_vld),
        .o_pop   (w_q_pop),
        .i_hop   (w_q_hop),
        .o_vld   (o_m_tvalid),
        .i_rdy   (i_m_tready),
        .o_res   (w_res)
    );

    assign o_m_tdata = {3'b000,
                        w_res.best_route_index,
                        w_res.best_value,
                        w_res.rec_cost,
                        w_res.have_best,
                        w_res.new_best,
                        w_res.route_value,
                        w_res.route_cost,
                        w_res.route_valid};

    // a new best is always a valid route and leaves a best behind
    a_best_is_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_res.new_best |-> w_res.route_valid && w_res.have_best)
        else $error("new best from an invalid route");

    // a new best is reported as the record
    a_best_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_res.new_best |->
            w_res.rec_cost == w_res.route_cost && w_res.best_value == w_res.route_value)
        else $error("best record differs from winning route");

    // with no best yet the record holds its initial ratio
    a_no_best_init : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !w_res.have_best |->
            w_res.rec_cost == rcbr_pkg::COST_ONE && w_res.best_value == '0 &&
            w_res.best_route_index == '0 && !w_res.new_best)
        else $error("best record changed without a best");

endmodule

[verif/route_check_and_best_ratio_tb.sv]
module route_check_and_best_ratio_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // kind code that the block must swallow without effect
    localparam rcbr_pkg::t_kind KIND_SPARE = 2'd3;

    localparam int SETTLE_CYCLES = 20;      // idle wait after draining owed results
    localparam int CYCLE_LIMIT   = 200000;  // watchdog, many times the slowest good run
    localparam int PHASE_WORDS   = 55;      // random words per capacity setting

    // one input word, fields as the block sees them
    typedef struct {
        rcbr_pkg::t_kind                kind;
        logic [3:0]                     from;
        logic [3:0]                     to;
        logic [rcbr_pkg::WT_W-1:0]      weight;
        logic                           exists;
        logic [rcbr_pkg::DEM_W-1:0]     demand;
        logic                           last;
    } t_word;

    // Route predictor plus queue of route results still owed by the block.
    class route_scoreboard;
        bit                          edge_on [rcbr_pkg::EDGE_DEPTH];
        logic [rcbr_pkg::WT_W-1:0]   edge_cost [rcbr_pkg::EDGE_DEPTH];
        logic [rcbr_pkg::DEM_W-1:0]  node_demand [rcbr_pkg::NODE_COUNT];
        logic [rcbr_pkg::LOAD_W-1:0] capacity;
        logic [3:0]                  here;
        logic [rcbr_pkg::LOAD_W-1:0] load;
        logic [rcbr_pkg::COST_W-1:0] cost;
        bit                          route_ok;
        logic [rcbr_pkg::IDX_W-1:0]  arrivals;
        logic [rcbr_pkg::LOAD_W-1:0] best_v;
        logic [rcbr_pkg::COST_W-1:0] best_c;
        logic [rcbr_pkg::IDX_W-1:0]  best_idx;
        bit                          best_seen;
        rcbr_pkg::t_result           owed_q[$];
        int                          errors;

        function new();
            foreach (edge_on[i]) begin
                edge_on[i]   = 1'b0;
                edge_cost[i] = '0;
            end
            foreach (node_demand[i]) node_demand[i] = '0;
            capacity  = rcbr_pkg::CAP_RESET;
            here      = '0;
            load      = '0;
            cost      = '0;
            route_ok  = 1'b1;
            arrivals  = '0;
            best_v    = '0;
            best_c    = rcbr_pkg::COST_ONE;
            best_idx  = '0;
            best_seen = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Advance the predictor by one accepted word.
        function void note_input(t_word w);
            int unsigned                     slot;
            logic [rcbr_pkg::LOAD_W:0]       load_sum;
            logic [rcbr_pkg::COST_W:0]       cost_sum;
            logic [rcbr_pkg::PROD_W-1:0]     lhs;
            logic [rcbr_pkg::PROD_W-1:0]     rhs;
            rcbr_pkg::t_result               r;
            case (w.kind)
                rcbr_pkg::KIND_EDGE: begin
                    slot = {w.from, w.to};
                    edge_cost[slot] = w.weight;
                    edge_on[slot]   = w.exists;
                end
                rcbr_pkg::KIND_DEMAND: begin
                    node_demand[w.from] = w.demand;
                end
                rcbr_pkg::KIND_NODE: begin
                    if (route_ok) begin
                        slot     = {here, w.to};
                        load_sum = {1'b0, load} + node_demand[w.to];
                        if (!edge_on[slot]) begin
                            route_ok = 1'b0;
                        end else if (load_sum > {1'b0, capacity}) begin
                            route_ok = 1'b0;
                        end else begin
                            load     = load_sum[rcbr_pkg::LOAD_W-1:0];
                            cost_sum = {1'b0, cost} + edge_cost[slot];
                            cost     = cost_sum[rcbr_pkg::COST_W] ? rcbr_pkg::COST_MAX
                                                                  : cost_sum[rcbr_pkg::COST_W-1:0];
                        end
                    end
                    here = w.to;
                    if (w.last) begin
                        r.new_best = 1'b0;
                        if (route_ok) begin
                            // exact ratio test, strictly greater wins
                            lhs = rcbr_pkg::PROD_W'(load) * rcbr_pkg::PROD_W'(best_c);
                            rhs = rcbr_pkg::PROD_W'(best_v) * rcbr_pkg::PROD_W'(cost);
                            if (lhs > rhs) begin
                                r.new_best = 1'b1;
                                best_seen  = 1'b1;
                                best_v     = load;
                                best_c     = cost;
                                best_idx   = arrivals;
                            end
                        end
                        if (arrivals != rcbr_pkg::IDX_MAX) arrivals = arrivals + 1'b1;
                        r.route_valid      = route_ok;
                        r.route_cost       = cost;
                        r.route_value      = load;
                        r.have_best        = best_seen;
                        r.rec_cost         = best_c;
                        r.best_value       = best_v;
                        r.best_route_index = best_idx;
                        owed_q = {owed_q, r};
                        here     = '0;
                        load     = '0;
                        cost     = '0;
                        route_ok = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned seen);
            if (want != seen) begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
            end
        endfunction

        // Compare one result word from the block with the oldest owed result.
        function void check_result(logic [111:0] d);
            rcbr_pkg::t_result want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result word expected none got %h", $time, d);
                return;
            end
            want = owed_q.pop_front();
            compare_field("route_valid", want.route_valid, d[0]);
            compare_field("route_cost", want.route_cost, d[21:1]);
            compare_field("route_value", want.route_value, d[37:22]);
            compare_field("new_best", want.new_best, d[38]);
            compare_field("have_best", want.have_best, d[39]);
            compare_field("rec_cost", want.rec_cost, d[60:40]);
            compare_field("best_value", want.best_value, d[76:61]);
            compare_field("best_route_index", want.best_route_index, d[108:77]);
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [39:0]                   i_s_tdata;
    logic                          i_s_tlast;
    logic [1:0]                    i_s_tuser;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [111:0]                  o_m_tdata;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [rcbr_pkg::LOAD_W-1:0]   i_cfg_data;

    route_scoreboard board;
    bit              steady;        // set: neither side idles
    int              words_fed;     // words other than the spare kind
    int              cycles;

    route_check_and_best_ratio DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: check every word taken, then pick next cycle's ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata);
        i_m_tready <= steady || ($urandom_range(99) >= 14);
    end

    // Present one word, hold it until taken, then tell the predictor.
    // Valid is left high afterwards; the next call decides whether to drop it.
    task automatic send_word(input t_word w);
        while (!steady && $urandom_range(99) < 14) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, w.demand, w.exists, w.weight, w.to, w.from};
        i_s_tuser  <= w.kind;
        i_s_tlast  <= w.last;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_input(w);
        if (w.kind != KIND_SPARE) words_fed++;
    endtask

    // Drain owed results, then give the back end time to swallow
    // writes and middle nodes that produce nothing.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [rcbr_pkg::LOAD_W-1:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.capacity = cap;
    endtask

    // all fields random, so unused fields carry junk too
    function automatic t_word junk_word();
        t_word w;
        w.kind   = rcbr_pkg::t_kind'($urandom_range(3));
        w.from   = 4'($urandom);
        w.to     = 4'($urandom);
        w.weight = rcbr_pkg::WT_W'($urandom);
        w.exists = 1'($urandom);
        w.demand = rcbr_pkg::DEM_W'($urandom);
        w.last   = 1'($urandom);
        return w;
    endfunction

    function automatic t_word edge_word(input logic [3:0] from, input logic [3:0] to,
                                        input logic [rcbr_pkg::WT_W-1:0] wt, input logic on);
        t_word w;
        w = '{rcbr_pkg::KIND_EDGE, from, to, wt, on, '0, 1'b0};
        return w;
    endfunction

    function automatic t_word demand_word(input logic [3:0] node,
                                          input logic [rcbr_pkg::DEM_W-1:0] amt);
        t_word w;
        w = '{rcbr_pkg::KIND_DEMAND, node, '0, '0, 1'b0, amt, 1'b0};
        return w;
    endfunction

    function automatic t_word node_word(input logic [3:0] to, input logic last);
        t_word w;
        w = '{rcbr_pkg::KIND_NODE, '0, to, '0, 1'b0, '0, last};
        return w;
    endfunction

    // edge costs lean on the extremes
    function automatic logic [rcbr_pkg::WT_W-1:0] pick_weight();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) return '0;
        if (roll < 30) return '1;
        if (roll < 65) return rcbr_pkg::WT_W'($urandom_range(255));
        return rcbr_pkg::WT_W'($urandom);
    endfunction

    // demands mostly small so that routes fit the tighter capacities
    function automatic logic [rcbr_pkg::DEM_W-1:0] pick_demand();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30) return '0;
        if (roll < 75) return rcbr_pkg::DEM_W'($urandom_range(1, 15));
        return rcbr_pkg::DEM_W'($urandom);
    endfunction

    // table writes with random junk in the fields they do not use
    task automatic send_table_write();
        t_word w;
        w = junk_word();
        if ($urandom_range(99) < 70) begin
            w.kind   = rcbr_pkg::KIND_EDGE;
            w.weight = pick_weight();
            w.exists = ($urandom_range(99) < 85);
        end else begin
            w.kind   = rcbr_pkg::KIND_DEMAND;
            w.demand = pick_demand();
        end
        send_word(w);
    endtask

    // One route. Most hops follow a present edge that the load allows,
    // judged from the predictor's live state; the rest go anywhere.
    task automatic send_route();
        int          hops;
        int          pick;
        logic [3:0]  next;
        bit          is_end;
        bit          to_depot;
        int          ok_nodes[$];
        t_word       w;
        hops = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 14);
        for (int h = 0; h < hops; h++) begin
            if ($urandom_range(99) < 5) begin
                if ($urandom_range(1)) begin
                    w = junk_word();
                    w.kind = KIND_SPARE;
                    send_word(w);
                end else begin
                    send_table_write();
                end
            end
            is_end   = (h == hops - 1);
            to_depot = 1'b0;
            ok_nodes.delete();
            next = 4'($urandom);
            if ($urandom_range(99) < 85) begin
                for (int n = 0; n < rcbr_pkg::NODE_COUNT; n++) begin
                    if (board.edge_on[{board.here, 4'(n)}] &&
                        (32'(board.load) + board.node_demand[n] <= 32'(board.capacity)))
                        ok_nodes = {ok_nodes, n};
                end
                foreach (ok_nodes[i]) if (ok_nodes[i] == 0) to_depot = 1'b1;
                if (is_end && to_depot && $urandom_range(99) < 80) begin
                    next = '0;
                end else if (ok_nodes.size() != 0) begin
                    pick = $urandom_range(ok_nodes.size() - 1);
                    next = 4'(ok_nodes[pick]);
                end
            end
            w = junk_word();
            w.kind = rcbr_pkg::KIND_NODE;
            w.to   = next;
            w.last = is_end;
            send_word(w);
        end
    endtask

    // Random traffic under one capacity: seed the tables, then mostly routes.
    task automatic run_phase();
        int start;
        t_word w;
        start = words_fed;
        repeat ($urandom_range(10, 24)) send_table_write();
        while (words_fed - start < PHASE_WORDS) begin
            if ($urandom_range(99) < 10) begin
                w = junk_word();
                if (w.kind == rcbr_pkg::KIND_NODE) w.kind = KIND_SPARE;
                send_word(w);
            end else begin
                send_route();
            end
        end
    endtask

    initial begin
        logic [rcbr_pkg::LOAD_W-1:0] caps[6];
        board      = new();
        steady     = 1'b0;
        words_fed  = 0;
        cycles     = 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        i_s_tuser   <= rcbr_pkg::KIND_EDGE;
        i_m_tready  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset capacity of 15.
        // Route over empty tables: missing edge, still counts as arrival 0.
        send_word(node_word(4'd3, 1'b1));
        // spare kind, even with tlast set, must be ignored
        send_word('{KIND_SPARE, 4'hF, 4'hF, '1, 1'b1, '1, 1'b1});
        send_word(edge_word(4'd0, 4'd1, 16'd10, 1'b1));
        send_word(edge_word(4'd1, 4'd2, 16'd20, 1'b1));
        send_word(edge_word(4'd2, 4'd0, 16'd30, 1'b1));
        send_word(demand_word(4'd1, 8'd5));
        send_word(demand_word(4'd2, 8'd10));
        // load of exactly the capacity is fine: first best
        send_word(node_word(4'd1, 1'b0));
        send_word(node_word(4'd2, 1'b0));
        send_word(node_word(4'd0, 1'b1));
        // over capacity at node 2: load and cost freeze at the hop before
        send_word(demand_word(4'd2, 8'd255));
        send_word(node_word(4'd1, 1'b0));
        send_word(node_word(4'd2, 1'b0));
        send_word(node_word(4'd0, 1'b1));
        // zero-cost route of nonzero value beats any best of nonzero cost
        send_word(edge_word(4'd0, 4'd3, 16'd0, 1'b1));
        send_word(demand_word(4'd3, 8'd1));
        send_word(node_word(4'd3, 1'b1));
        // zero over zero never wins
        send_word(edge_word(4'd0, 4'd0, 16'd0, 1'b1));
        send_word(node_word(4'd0, 1'b1));
        // removed edge, and a route ending away from the depot
        send_word(edge_word(4'd0, 4'd3, 16'hFFFF, 1'b0));
        send_word(node_word(4'd3, 1'b1));
        send_word(node_word(4'd1, 1'b1));
        // top node numbers and the largest demand
        send_word(edge_word(4'd15, 4'd15, 16'hFFFF, 1'b1));
        send_word(demand_word(4'd15, 8'd255));
        send_word(node_word(4'd15, 1'b1));
        wait_idle();

        // Cost saturation: a self-loop of full weight on the depot, 34 hops.
        write_capacity('1);
        send_word(edge_word(4'd0, 4'd0, 16'hFFFF, 1'b1));
        send_word(demand_word(4'd0, 8'd0));
        for (int h = 0; h < 34; h++) send_word(node_word(4'd0, h == 33));
        wait_idle();

        // Random part over several capacities, extremes included.
        caps[0] = '0;
        caps[1] = '1;
        caps[2] = rcbr_pkg::LOAD_W'($urandom);
        caps[3] = rcbr_pkg::LOAD_W'(255);
        caps[4] = rcbr_pkg::LOAD_W'(1);
        caps[5] = rcbr_pkg::LOAD_W'($urandom_range(16, 600));
        for (int p = 0; p < 6; p++) begin
            write_capacity(caps[p]);
            steady = (p == 2);      // one long run with neither side idling
            run_phase();
            wait_idle();
            steady = 1'b0;
        end

        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
